// File: src/ihex_pkg.sv
// Shared types, codes and the hex digit decoder of the Intel HEX parser.
package ihex_pkg;

	// Result kinds as seen on the kind port.
	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_END   = 2'd1,
		KIND_BAD   = 2'd2
	} kind_t;

	// Record types that the parser acts on.
	localparam logic [7:0] REC_DATA = 8'h00;
	localparam logic [7:0] REC_EOF  = 8'h01;
	localparam logic [7:0] REC_ULBA = 8'h04;

	// Characters with a meaning of their own.
	localparam logic [7:0] CHAR_COLON   = 8'h3A;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

	// Flash size after reset.
	localparam int unsigned      FLASH_W          = 25;
	localparam logic [FLASH_W-1:0] FLASH_SIZE_RESET = 25'd262144;

	// Header digit positions, counted from zero after the colon.
	localparam logic [9:0] POS_LEN      = 10'd1;
	localparam logic [9:0] POS_OFF_HI   = 10'd3;
	localparam logic [9:0] POS_OFF_LO   = 10'd5;
	localparam logic [9:0] POS_TYPE     = 10'd7;
	localparam logic [9:0] POS_FIRST_PL = 10'd9;

	// Request passed from the front part to the back part.
	typedef struct packed {
		kind_t       kind;
		logic [15:0] upper;
		logic [15:0] offset;
		logic [7:0]  idx;
		logic [7:0]  data;
	} op_t;

	// Result request held in the output queue.
	typedef struct packed {
		kind_t       kind;
		logic [31:0] addr;
		logic [7:0]  data;
	} res_t;

	// Hex digit decode: bit 4 is the valid flag, bits 3:0 the value.
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end
		return r;
	endfunction

endpackage

// File: src/intel_hex_record_parser_unit.sv
// Intel HEX record parser: one character a cycle in, flash byte writes out.
// Throughput: one character per cycle while full is low and results are popped.
// Path: a taken character's request is registered in the request queue; the write stage
// moves it on, when the result queue has room, into that queue, whose head drives the outputs.
// Reset clears the parser state and both queues and sets flash_size to 262144.
module intel_hex_record_parser_unit #(
	parameter int unsigned OP_DEPTH  = 4,
	parameter int unsigned RES_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  character,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  kind,
	output logic [31:0] write_address,
	output logic [7:0]  write_data,
	input  logic        cfg_we,
	input  logic [24:0] cfg_wdata
);

	logic           take;
	logic           op_valid;
	ihex_pkg::op_t  op_in;
	ihex_pkg::op_t  op_out;
	logic           op_empty;
	logic           op_take;
	logic           res_full;
	logic           res_valid;
	ihex_pkg::res_t res_in;
	ihex_pkg::res_t res_out;

	assign take = push && !full;

	// Front part: parses characters into requests.
	ihex_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.character(character),
		.op_valid (op_valid),
		.op       (op_in)
	);

	// Request queue between the parser and the write stage.
	ihex_fifo #(
		.WIDTH($bits(ihex_pkg::op_t)),
		.DEPTH(OP_DEPTH)
	) u_op_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (op_valid),
		.wr_data(op_in),
		.full   (full),
		.rd_en  (op_take),
		.rd_data(op_out),
		.empty  (op_empty)
	);

	// Back part: forms addresses and filters by flash size.
	ihex_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.op_avail (!op_empty),
		.op       (op_out),
		.op_take  (op_take),
		.res_full (res_full),
		.res_valid(res_valid),
		.res      (res_in)
	);

	// Result queue seen by the consumer.
	ihex_fifo #(
		.WIDTH($bits(ihex_pkg::res_t)),
		.DEPTH(RES_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (res_valid),
		.wr_data(res_in),
		.full   (res_full),
		.rd_en  (pop),
		.rd_data(res_out),
		.empty  (empty)
	);

	assign kind          = res_out.kind;
	assign write_address = res_out.addr;
	assign write_data    = res_out.data;

endmodule

// File: src/ihex_fifo.sv
// Small register queue used between the parser stages and at the result side.
module ihex_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Storage is written only at the tail; it needs no reset.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers wrap at the depth, the count tracks occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: src/ihex_front.sv
// Character parser: tracks the record fields and classifies each character.
module ihex_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          take,
	input  logic [7:0]    character,
	output logic          op_valid,
	output ihex_pkg::op_t op
);

	typedef enum logic [1:0] {
		MODE_START,
		MODE_RECORD,
		MODE_SKIP
	} mode_t;

	mode_t       mode_q, mode_n;
	logic [9:0]  pos_q, pos_n;
	logic [3:0]  hn_q, hn_n;
	logic [7:0]  len_q, len_n;
	logic [15:0] off_q, off_n;
	logic [7:0]  rkind_q, rkind_n;
	logic [15:0] upper_q, upper_n;
	logic        fin_q, fin_n;

	logic [4:0]  hv;
	logic [7:0]  b;
	logic [8:0]  idx_full;
	logic [7:0]  idx;

	assign hv       = ihex_pkg::hex_value(character);
	assign b        = {hn_q, hv[3:0]};
	// Data byte index is (position - 9) / 2 for odd positions.
	assign idx_full = pos_q[9:1] - 9'd4;
	assign idx      = idx_full[7:0];

	// Next state and the request for the back part.
	always_comb begin
		mode_n    = mode_q;
		pos_n     = pos_q;
		hn_n      = hn_q;
		len_n     = len_q;
		off_n     = off_q;
		rkind_n   = rkind_q;
		upper_n   = upper_q;
		fin_n     = fin_q;
		op_valid  = 1'b0;
		op.kind   = ihex_pkg::KIND_BAD;
		op.upper  = '0;
		op.offset = '0;
		op.idx    = '0;
		op.data   = '0;
		if (take && !fin_q) begin
			unique case (mode_q)
				MODE_START: begin
					if (character == ihex_pkg::CHAR_COLON) begin
						mode_n = MODE_RECORD;
						pos_n  = '0;
					end else if (character != ihex_pkg::CHAR_NEWLINE) begin
						mode_n = MODE_SKIP;
					end
				end
				MODE_SKIP: begin
					if (character == ihex_pkg::CHAR_NEWLINE) begin
						mode_n = MODE_START;
					end
				end
				MODE_RECORD: begin
					if (!hv[4]) begin
						// A stray character spoils the record.
						mode_n   = (character == ihex_pkg::CHAR_NEWLINE) ? MODE_START : MODE_SKIP;
						op_valid = 1'b1;
						op.kind  = ihex_pkg::KIND_BAD;
					end else begin
						pos_n = pos_q + 1'b1;
						if (!pos_q[0]) begin
							hn_n = hv[3:0];
						end else if (pos_q == ihex_pkg::POS_LEN) begin
							len_n = b;
						end else if (pos_q == ihex_pkg::POS_OFF_HI) begin
							off_n = {b, 8'h00};
						end else if (pos_q == ihex_pkg::POS_OFF_LO) begin
							off_n = off_q | {8'h00, b};
						end else if (pos_q == ihex_pkg::POS_TYPE) begin
							rkind_n = b;
							if (b == ihex_pkg::REC_EOF) begin
								fin_n    = 1'b1;
								mode_n   = MODE_START;
								op_valid = 1'b1;
								op.kind  = ihex_pkg::KIND_END;
							end else if (b == ihex_pkg::REC_ULBA) begin
								off_n = '0;
							end else if (b != ihex_pkg::REC_DATA || len_q == '0) begin
								mode_n = MODE_SKIP;
							end
						end else if (rkind_q == ihex_pkg::REC_ULBA) begin
							// Upper address record: two payload bytes.
							if (pos_q == ihex_pkg::POS_FIRST_PL) begin
								off_n = {b, 8'h00};
							end else begin
								upper_n = off_q | {8'h00, b};
								mode_n  = MODE_SKIP;
							end
						end else begin
							// Data byte: the back part forms the address.
							if ({1'b0, idx} + 9'd1 >= {1'b0, len_q}) begin
								mode_n = MODE_SKIP;
							end
							op_valid  = 1'b1;
							op.kind   = ihex_pkg::KIND_WRITE;
							op.upper  = upper_q;
							op.offset = off_q;
							op.idx    = idx;
							op.data   = b;
						end
					end
				end
				default: begin
					mode_n = MODE_START;
				end
			endcase
		end
	end

	// Parser state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_START;
			pos_q   <= '0;
			hn_q    <= '0;
			len_q   <= '0;
			off_q   <= '0;
			rkind_q <= '0;
			upper_q <= '0;
			fin_q   <= 1'b0;
		end else begin
			mode_q  <= mode_n;
			pos_q   <= pos_n;
			hn_q    <= hn_n;
			len_q   <= len_n;
			off_q   <= off_n;
			rkind_q <= rkind_n;
			upper_q <= upper_n;
			fin_q   <= fin_n;
		end
	end

endmodule

// File: src/ihex_back.sv
// Write stage: forms flash addresses, applies the size limit, holds flash_size.
module ihex_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [ihex_pkg::FLASH_W-1:0]       cfg_wdata,
	input  logic                               op_avail,
	input  ihex_pkg::op_t                      op,
	output logic                               op_take,
	input  logic                               res_full,
	output logic                               res_valid,
	output ihex_pkg::res_t                     res
);

	logic [ihex_pkg::FLASH_W-1:0] flash_size_q;
	logic [31:0]                  addr;
	logic                         in_range;

	// Address is (upper << 16) + offset + index, modulo 2^32.
	assign addr     = {op.upper, 16'h0000} + {16'h0000, op.offset} + {24'h000000, op.idx};
	assign in_range = addr < {7'd0, flash_size_q};

	assign op_take = op_avail && !res_full;

	// Writes outside the flash are dropped; other requests pass with zero fields.
	always_comb begin
		res.kind  = op.kind;
		res.addr  = '0;
		res.data  = '0;
		res_valid = op_take;
		if (op.kind == ihex_pkg::KIND_WRITE) begin
			res.addr  = addr;
			res.data  = op.data;
			res_valid = op_take && in_range;
		end
	end

	// Flash size register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flash_size_q <= ihex_pkg::FLASH_SIZE_RESET;
		end else if (cfg_we) begin
			flash_size_q <= cfg_wdata;
		end
	end

endmodule
